// ===== design/bceg_pkg.sv =====
package bceg_pkg;

   localparam int IN_W  = 17;
   localparam int OUT_W = 41;
   localparam int INV_W = 33;
   localparam int EPS_W = 17;
   localparam int INV_LO_W = 17;
   localparam int INV_HI_W = INV_W - INV_LO_W;
   localparam int CMP_W = 64;

   localparam logic [OUT_W-1:0] POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

   localparam logic [INV_W-1:0] INV_COUNT_RESET = {1'b1, {(INV_W-1){1'b0}}};
   localparam logic [EPS_W-1:0] EPSILON_RESET   = EPS_W'(1);

   typedef enum logic [0:0] {
      CSR_INV_COUNT = 1'b0,
      CSR_EPSILON   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic inf;
      logic inf_neg;
      logic qb_neg;
      logic a_zero;
      logic b_zero;
   } ctrl_type;

endpackage

// ===== design/bceg_div.sv =====
module bceg_div #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 18
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [NUM_W-1:0] quo_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic [DEN_W-1:0] rem_src;
      logic [NUM_W-1:0] num_src;
      logic [NUM_W-1:0] quo_src;
      logic [DEN_W-1:0] den_src;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] quo_in;

      if (i == 0) begin : g_first
         assign rem_src = '0;
         assign num_src = num;
         assign quo_src = '0;
         assign den_src = den;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign num_src = num_ff[i-1];
         assign quo_src = quo_ff[i-1];
         assign den_src = den_ff[i-1];
      end

      assign trial  = {rem_src, num_src[NUM_W-1]};
      assign diff   = trial - {1'b0, den_src};
      assign ge     = trial >= {1'b0, den_src};
      assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign quo_in = {quo_src[NUM_W-2:0], ge};

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in;
         num_ff[i] <= {num_src[NUM_W-2:0], 1'b0};
         quo_ff[i] <= quo_in;
         den_ff[i] <= den_src;
      end
   end

   assign quo = quo_ff[NUM_W-1];

endmodule

// ===== design/bceg_scale.sv =====
module bceg_scale #(
   parameter int QW = 33
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bceg_pkg::ctrl_type           ctrl,
   input  logic [QW-1:0]                quo_a,
   input  logic [QW-1:0]                quo_b,
   input  logic [bceg_pkg::INV_W-1:0]   inv_count,
   output logic                         out_valid,
   output logic [bceg_pkg::OUT_W-1:0]   out_gradient,
   output logic                         out_saturated
);
   import bceg_pkg::*;

   localparam int SW  = QW + 2;
   localparam int MW  = QW + 1;
   localparam int PW0 = MW + INV_LO_W;
   localparam int PW1 = MW + INV_HI_W;
   localparam int FW  = MW + INV_W;
   localparam int RW  = FW - 32;

   ctrl_type ctrl_ff [5];

   logic signed [SW-1:0] sa_ff, sb_ff, s_ff;
   logic signed [SW-1:0] sa_in, sb_in, s_in;
   logic [QW-1:0]        qa_eff, qb_eff;
   logic [MW-1:0]        m_ff, m_in;
   logic                 neg_ff [3];
   logic [PW0-1:0]       p0_ff, p0_in;
   logic [PW1-1:0]       p1_ff, p1_in;
   logic [FW-1:0]        full;
   logic [RW-1:0]        r_ff;
   logic [CMP_W-1:0]     r_ext;
   logic [CMP_W-1:0]     r_neg;

   logic                 valid_ff, valid_in;
   logic [OUT_W-1:0]     gradient_ff, gradient_in;
   logic                 saturated_ff, saturated_in;

   always_comb begin
      qa_eff = ctrl.a_zero ? '0 : quo_a;
      qb_eff = ctrl.b_zero ? '0 : quo_b;
      sa_in  = -$signed(SW'(qa_eff));
      sb_in  = ctrl.qb_neg ? -$signed(SW'(qb_eff)) : $signed(SW'(qb_eff));
      s_in   = sa_ff + sb_ff;
      m_in   = s_ff[SW-1] ? MW'(-s_ff) : MW'(s_ff);
      p0_in  = PW0'(m_ff) * PW0'(inv_count[INV_LO_W-1:0]);
      p1_in  = PW1'(m_ff) * PW1'(inv_count[INV_W-1:INV_LO_W]);
      full   = FW'(p0_ff) + (FW'(p1_ff) << INV_LO_W);
   end

   always_comb begin
      r_ext        = CMP_W'(r_ff);
      r_neg        = CMP_W'(0) - r_ext;
      valid_in     = ctrl_ff[4].valid;
      saturated_in = 1'b0;
      gradient_in  = '0;
      priority if (ctrl_ff[4].inf) begin
         saturated_in = 1'b1;
         gradient_in  = ctrl_ff[4].inf_neg ? NEG_LIMIT : POS_LIMIT;
      end else if (neg_ff[2]) begin
         if (r_ext > CMP_W'(NEG_LIMIT)) begin
            saturated_in = 1'b1;
            gradient_in  = NEG_LIMIT;
         end else begin
            gradient_in  = r_neg[OUT_W-1:0];
         end
      end else begin
         if (r_ext > CMP_W'(POS_LIMIT)) begin
            saturated_in = 1'b1;
            gradient_in  = POS_LIMIT;
         end else begin
            gradient_in  = r_ext[OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            ctrl_ff[i] <= '0;
         end
         valid_ff <= 1'b0;
      end else begin
         ctrl_ff[0] <= ctrl;
         for (int i = 1; i < 5; i++) begin
            ctrl_ff[i] <= ctrl_ff[i-1];
         end
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff        <= sa_in;
      sb_ff        <= sb_in;
      s_ff         <= s_in;
      m_ff         <= m_in;
      neg_ff[0]    <= s_ff[SW-1];
      p0_ff        <= p0_in;
      p1_ff        <= p1_in;
      neg_ff[1]    <= neg_ff[0];
      r_ff         <= full[FW-1:32];
      neg_ff[2]    <= neg_ff[1];
      gradient_ff  <= gradient_in;
      saturated_ff <= saturated_in;
   end

   assign out_valid     = valid_ff;
   assign out_gradient  = gradient_ff;
   assign out_saturated = saturated_ff;

endmodule

// ===== design/binary_cross_entropy_gradient.sv =====
// Channel   Ports                                          Direction
// request   start, busy, req_pred_prob, req_target         in (busy out)
// response  rsp_valid, rsp_gradient, rsp_saturated         out
// csr       csr_write_enable, csr_index, csr_data          in
//
// A request is taken on every cycle that start is high; busy is always low.
// The response passes an input register, the two bit-per-stage dividers, which run in
// parallel, and then the scaling pipeline, which registers the result.
// Reset is synchronous; it clears the pipeline valid bits and loads the CSR reset values.
// The receiver cannot stall, so the pipeline never holds.
module binary_cross_entropy_gradient #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bceg_pkg::IN_W-1:0]     req_pred_prob,
   input  logic [bceg_pkg::IN_W-1:0]     req_target,
   output logic                          rsp_valid,
   output logic [bceg_pkg::OUT_W-1:0]    rsp_gradient,
   output logic                          rsp_saturated,
   input  logic                          csr_write_enable,
   input  bceg_pkg::csr_index_type       csr_index,
   input  logic [bceg_pkg::INV_W-1:0]    csr_data
);
   import bceg_pkg::*;

   localparam int NW  = (FRAC_BITS >= 16) ? FRAC_BITS + 1 : IN_W;
   localparam int DMW = NW + 1;
   localparam int DW  = NW + 2;
   localparam int QW  = NW + FRAC_BITS;
   localparam logic [DW-1:0] ONE_D = DW'(1) << FRAC_BITS;
   localparam logic [NW:0]   ONE_N = (NW + 1)'(1) << FRAC_BITS;

   logic [INV_W-1:0] inv_count_ff;
   logic [EPS_W-1:0] epsilon_ff;

   logic [DMW-1:0] d1;
   logic [DW-1:0]  d2;
   logic [NW:0]    n2;
   logic           n2_neg, d2_neg, za, zb;
   ctrl_type       ctrl_in;

   ctrl_type       ctrl0_ff;
   logic [NW-1:0]  n1_ff, n2_ff;
   logic [DMW-1:0] d1_ff, d2_ff;
   ctrl_type       ctrl_pipe_ff [QW];

   logic [QW-1:0]  quo_a, quo_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_count_ff <= INV_COUNT_RESET;
         epsilon_ff   <= EPSILON_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INV_COUNT: inv_count_ff <= csr_data;
            CSR_EPSILON:   epsilon_ff   <= csr_data[EPS_W-1:0];
            default:       inv_count_ff <= inv_count_ff;
         endcase
      end
   end

   always_comb begin
      d1      = DMW'(req_pred_prob) + DMW'(epsilon_ff);
      d2      = ONE_D - DW'(req_pred_prob) + DW'(epsilon_ff);
      n2      = ONE_N - (NW + 1)'(req_target);
      n2_neg  = n2[NW];
      d2_neg  = d2[DW-1];
      za      = (req_target != '0) && (d1 == '0);
      zb      = (n2 != '0) && (d2 == '0);
      ctrl_in.valid   = start;
      ctrl_in.inf     = za | zb;
      ctrl_in.inf_neg = za | n2_neg;
      ctrl_in.qb_neg  = n2_neg ^ d2_neg;
      ctrl_in.a_zero  = (d1 == '0);
      ctrl_in.b_zero  = (d2 == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl0_ff <= '0;
         for (int i = 0; i < QW; i++) begin
            ctrl_pipe_ff[i] <= '0;
         end
      end else begin
         ctrl0_ff        <= ctrl_in;
         ctrl_pipe_ff[0] <= ctrl0_ff;
         for (int i = 1; i < QW; i++) begin
            ctrl_pipe_ff[i] <= ctrl_pipe_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      n1_ff <= NW'(req_target);
      d1_ff <= d1;
      n2_ff <= n2_neg ? NW'(-n2) : NW'(n2);
      d2_ff <= d2_neg ? DMW'(-d2) : DMW'(d2);
   end

   bceg_div #(.NUM_W(QW), .DEN_W(DMW)) u_div_a (
      .clock (clock),
      .num   ({n1_ff, {FRAC_BITS{1'b0}}}),
      .den   (d1_ff),
      .quo   (quo_a)
   );

   bceg_div #(.NUM_W(QW), .DEN_W(DMW)) u_div_b (
      .clock (clock),
      .num   ({n2_ff, {FRAC_BITS{1'b0}}}),
      .den   (d2_ff),
      .quo   (quo_b)
   );

   bceg_scale #(.QW(QW)) u_scale (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl_pipe_ff[QW-1]),
      .quo_a         (quo_a),
      .quo_b         (quo_b),
      .inv_count     (inv_count_ff),
      .out_valid     (rsp_valid),
      .out_gradient  (rsp_gradient),
      .out_saturated (rsp_saturated)
   );

   assign busy = 1'b0;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import bceg_pkg::*;

   localparam int FRAC = 16;
   localparam int PIPE_LATENCY = 40;
   localparam longint ONE = 64'sd1 << FRAC;

   typedef struct {
      logic [IN_W-1:0] pred_prob;
      logic [IN_W-1:0] target;
   } element_type;

   typedef struct {
      logic [OUT_W-1:0] gradient;
      logic             saturated;
   } gradient_type;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 start = 0;
   logic                 busy;
   logic [IN_W-1:0]      req_pred_prob = '0;
   logic [IN_W-1:0]      req_target = '0;
   logic                 rsp_valid;
   logic [OUT_W-1:0]     rsp_gradient;
   logic                 rsp_saturated;
   logic                 csr_write_enable = 0;
   csr_index_type        csr_index = CSR_INV_COUNT;
   logic [INV_W-1:0]     csr_data = '0;

   logic [INV_W-1:0]     inv_count_shadow;
   logic [EPS_W-1:0]     epsilon_shadow;

   element_type          pending_elements[$];
   gradient_type         expected_gradients[$];
   int                   mismatch_count = 0;
   int                   gap_left = 0;
   bit                   driving_enabled = 0;

   binary_cross_entropy_gradient #(.FRAC_BITS(FRAC)) uut (.*);

   always #5 clock = ~clock;

   function automatic longint scaled_quotient(longint num, longint den, output int zero_sign);
      longint un, ud, q;
      zero_sign = 0;
      un = num < 0 ? -num : num;
      ud = den < 0 ? -den : den;
      if (un == 0) return 0;
      if (ud == 0) begin
         zero_sign = num < 0 ? -1 : 1;
         return 0;
      end
      q = (un << FRAC) / ud;
      return ((num < 0) != (den < 0)) ? -q : q;
   endfunction

   function automatic gradient_type compute_gradient(element_type e);
      gradient_type g;
      longint p, y, eps, qa, qb, s;
      int za, zb, inf;
      logic [127:0] product;
      logic [63:0] mag;
      p = e.pred_prob;
      y = e.target;
      eps = epsilon_shadow;
      qa = scaled_quotient(-y, p + eps, za);
      qb = scaled_quotient(ONE - y, ONE - p + eps, zb);
      inf = za != 0 ? za : zb;
      g.saturated = 0;
      if (inf != 0) begin
         g.saturated = 1;
         g.gradient = inf > 0 ? POS_LIMIT : NEG_LIMIT;
      end else begin
         s = qa + qb;
         mag = s < 0 ? -s : s;
         product = (128'(mag) * 128'(inv_count_shadow)) >> 32;
         if (s < 0) begin
            if (product > 128'(NEG_LIMIT)) begin
               product = 128'(NEG_LIMIT);
               g.saturated = 1;
            end
            g.gradient = OUT_W'(-product);
         end else begin
            if (product > 128'(POS_LIMIT)) begin
               product = 128'(POS_LIMIT);
               g.saturated = 1;
            end
            g.gradient = OUT_W'(product);
         end
      end
      return g;
   endfunction

   always @(posedge clock) begin
      element_type e;
      if (reset || !driving_enabled) begin
         start <= 0;
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         start <= 0;
      end else if (start && !busy) begin
         if (pending_elements.size() > 0 && $urandom_range(0, 9) != 0) begin
            e = pending_elements.pop_front();
            req_pred_prob <= e.pred_prob;
            req_target <= e.target;
         end else begin
            start <= 0;
            gap_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40)
                                                     : $urandom_range(0, 3);
         end
      end else if (!start && pending_elements.size() > 0) begin
         e = pending_elements.pop_front();
         req_pred_prob <= e.pred_prob;
         req_target <= e.target;
         start <= 1;
      end
   end

   // The prediction is made when the transfer is accepted.
   always @(posedge clock) begin
      if (!reset && start && !busy)
         expected_gradients.push_back(compute_gradient('{req_pred_prob, req_target}));
   end

   always @(posedge clock) begin
      gradient_type want;
      if (!reset && rsp_valid) begin
         if (expected_gradients.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_gradient);
         end else begin
            want = expected_gradients.pop_front();
            if (want.gradient !== rsp_gradient || want.saturated !== rsp_saturated) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %h/%b actual %h/%b", want.gradient,
                           want.saturated, rsp_gradient, rsp_saturated);
            end
         end
      end
   end

   task automatic write_register(csr_index_type idx, logic [INV_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      if (idx == CSR_INV_COUNT) inv_count_shadow = value;
      else epsilon_shadow = EPS_W'(value);
   endtask

   task automatic push_element(logic [IN_W-1:0] p, logic [IN_W-1:0] y);
      pending_elements.push_back('{p, y});
   endtask

   function automatic logic [IN_W-1:0] random_field();
      case ($urandom_range(0, 5))
         0: return IN_W'($urandom_range(0, 65536));
         1: return IN_W'($urandom_range(0, 16));
         2: return IN_W'($urandom_range(65520, 65536));
         3: return IN_W'($urandom);
         default: return IN_W'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic drain();
      driving_enabled = 1;
      wait (pending_elements.size() == 0 && !start);
      wait (expected_gradients.size() == 0);
      repeat (PIPE_LATENCY + 5) @(posedge clock);
      driving_enabled = 0;
      @(posedge clock);
   endtask

   initial begin
      logic [INV_W-1:0] inv_settings[6];
      logic [EPS_W-1:0] eps_settings[6];
      inv_count_shadow = INV_COUNT_RESET;
      epsilon_shadow = EPSILON_RESET;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (inv_settings[i]) begin
      end
      push_element(0, 0);
      push_element(0, 65536);
      push_element(65536, 0);
      push_element(65536, 65536);
      push_element(32768, 32768);
      push_element(17'h1FFFF, 0);
      push_element(17'h1FFFF, 17'h1FFFF);
      push_element(0, 17'h1FFFF);
      push_element(65537, 65536);
      push_element(1, 65535);
      drain();

      inv_settings = '{33'h1_0000_0000, 0, 1, 33'h1_FFFF_FFFF, 33'h0_0100_0000, 33'h0_8000_0000};
      eps_settings = '{0, 65536, 17'h1FFFF, 1, 16, 300};
      for (int phase = 0; phase < 8; phase++) begin
         if (phase < 6) begin
            write_register(CSR_INV_COUNT, inv_settings[phase]);
            write_register(CSR_EPSILON, INV_W'(eps_settings[phase]));
         end else begin
            write_register(CSR_INV_COUNT, {$urandom, 1'($urandom)});
            write_register(CSR_EPSILON, INV_W'(EPS_W'($urandom)));
         end
         if (phase == 0) begin
            push_element(0, 0);
            push_element(0, 65536);
            push_element(65536, 0);
            push_element(65536, 65536);
            push_element(65536, 32768);
            push_element(0, 1);
         end
         for (int i = 0; i < 190; i++) push_element(random_field(), random_field());
         drain();
      end

      if (mismatch_count == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
